FILE: hw/rtl/dad_pkg.sv
// shared types, constants and calendar functions for the date adder
package dad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned ADD_W   = 16;
  localparam int unsigned REM_W   = 17;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 24;

  // multiplicative inverse of 25 modulo 2**14, and the largest quotient y/25
  localparam logic [YEAR_W-1:0] INV25   = 14'd7209;
  localparam logic [YEAR_W-1:0] MAX_Q25 = 14'd655;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_YEARS,
    ST_MONTHS,
    ST_FINISH
  } dad_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic year_step;
    logic month_step;
    logic out_load;
  } dad_cmd_t;

  typedef struct packed {
    logic bad;
    logic year_more;
    logic month_more;
  } dad_sts_t;

  // gregorian rule; divisibility by 25 through the inverse, so no divider
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              d25;
    p   = y * INV25;
    d25 = (p <= MAX_Q25);
    return (y[1:0] == 2'd0) && (!d25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/dad_ctrl.sv
// sequencer for the date adder: request intake, year and month stepping, result hand-off
module dad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  dad_pkg::dad_sts_t sts,
  output dad_pkg::dad_cmd_t cmd
);

  dad_pkg::dad_state_t state, state_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dad_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      dad_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = dad_pkg::ST_CHECK;
        end
      end
      dad_pkg::ST_CHECK: begin
        cmd.init   = 1'b1;
        state_next = sts.bad ? dad_pkg::ST_FINISH : dad_pkg::ST_YEARS;
      end
      dad_pkg::ST_YEARS: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_next = dad_pkg::ST_MONTHS;
        end
      end
      dad_pkg::ST_MONTHS: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_next = dad_pkg::ST_FINISH;
        end
      end
      dad_pkg::ST_FINISH: begin
        // wait until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = dad_pkg::ST_IDLE;
        end
      end
      default: state_next = dad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

FILE: hw/rtl/dad_dp.sv
// datapath for the date adder: day count, year and month registers, output register
module dad_dp (
  input  logic                              clk,
  input  logic [dad_pkg::DAY_W-1:0]         start_day,
  input  logic [dad_pkg::MONTH_W-1:0]       start_month,
  input  logic [dad_pkg::YEAR_W-1:0]        start_year,
  input  logic [dad_pkg::ADD_W-1:0]         days_to_add,
  input  dad_pkg::dad_cmd_t                 cmd,
  output dad_pkg::dad_sts_t                 sts,
  output logic [dad_pkg::DAY_W-1:0]         end_day,
  output logic [dad_pkg::MONTH_W-1:0]       end_month,
  output logic [dad_pkg::YEAR_W-1:0]        end_year,
  output logic                              bad_input
);

  logic [dad_pkg::DAY_W-1:0]   day_in;
  logic [dad_pkg::MONTH_W-1:0] month_in;
  logic [dad_pkg::ADD_W-1:0]   add_in;
  logic [dad_pkg::YEAR_W-1:0]  year;
  logic [dad_pkg::MONTH_W-1:0] mon;
  logic [dad_pkg::REM_W-1:0]   rem;
  logic                        bad;

  logic                        leap;
  logic [8:0]                  year_len;
  logic [dad_pkg::DAY_W-1:0]   start_len;
  logic [dad_pkg::DAY_W-1:0]   cur_len;
  logic                        invalid;
  logic [dad_pkg::REM_W-1:0]   rem_init;

  always_comb begin
    leap      = dad_pkg::is_leap(year);
    year_len  = leap ? 9'd366 : 9'd365;
    start_len = dad_pkg::month_len(month_in, leap);
    cur_len   = dad_pkg::month_len(mon, leap);
    invalid   = (month_in == 4'd0) || (month_in > dad_pkg::MONTH_DEC) ||
                (day_in == 5'd0) || (day_in > start_len);
    // zero-based day within the start year plus the days to add
    rem_init  = 17'(day_in) - 17'd1 + 17'(add_in) + 17'(dad_pkg::days_before(month_in)) +
                17'(leap && (month_in > dad_pkg::MONTH_FEB));
  end

  assign sts.bad        = invalid;
  assign sts.year_more  = (rem >= 17'(year_len));
  assign sts.month_more = (mon != dad_pkg::MONTH_DEC) && (rem >= 17'(cur_len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_in   <= start_day;
      month_in <= start_month;
      year     <= start_year;
      add_in   <= days_to_add;
    end else if (cmd.year_step) begin
      year <= year + 14'd1;
    end
    if (cmd.init) begin
      bad <= invalid;
      rem <= rem_init;
      mon <= dad_pkg::MONTH_JAN;
    end else if (cmd.year_step) begin
      rem <= rem - 17'(year_len);
    end else if (cmd.month_step) begin
      rem <= rem - 17'(cur_len);
      mon <= mon + 4'd1;
    end
    if (cmd.out_load) begin
      end_day   <= bad ? 5'd0 : rem[dad_pkg::DAY_W-1:0] + 5'd1;
      end_month <= bad ? 4'd0 : mon;
      end_year  <= bad ? 14'd0 : year;
      bad_input <= bad;
    end
  end

endmodule

FILE: hw/rtl/date_add_days_core.sv
// Gregorian date plus a day count, with a stream request in and one result out.
// Each request is checked, then stepped once per whole year crossed (about
// days_to_add / 365, at most 180) and once per month before the month of the end
// date, and then its result is loaded: one year or one month is subtracted from
// the running day count per cycle in the datapath. An invalid start date skips
// the stepping and goes straight from the check to the finish. The hand-off also
// waits for as long as the previous result still sits untaken in the output
// register. A new request is taken once the previous one is in the output
// register, even while that result still waits.
module date_add_days_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero pad
  input  logic [dad_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // end_day[4:0], end_month[8:5], end_year[22:9], zero pad
  output logic [dad_pkg::OUT_W-1:0]    m_tdata,
  // bad_input[0]
  output logic                         m_tuser
);

  dad_pkg::dad_cmd_t cmd;
  dad_pkg::dad_sts_t sts;

  logic [dad_pkg::DAY_W-1:0]   end_day;
  logic [dad_pkg::MONTH_W-1:0] end_month;
  logic [dad_pkg::YEAR_W-1:0]  end_year;

  dad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dad_dp u_dp (
    .clk         (clk),
    .start_day   (s_tdata[4:0]),
    .start_month (s_tdata[8:5]),
    .start_year  (s_tdata[22:9]),
    .days_to_add (s_tdata[38:23]),
    .cmd         (cmd),
    .sts         (sts),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year),
    .bad_input   (m_tuser)
  );

  assign m_tdata = {1'b0, end_year, end_month, end_day};

`ifndef NO_ASSERTIONS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad request result carries a non-zero date");

  a_good_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> end_day != 5'd0 && end_month != 4'd0 &&
                             end_month <= dad_pkg::MONTH_DEC)
    else $error("result date out of range");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded but not presented");
`endif

endmodule
